/* rtl/core/rcsa_pkg.sv */
// ----------------------------------------------------------------------------
// rcsa_pkg
// Shared widths, slot state encodings, command and status codes, and the
// request bundle between the controller and the slot memory.
// ----------------------------------------------------------------------------
package rcsa_pkg;

	localparam int DEF_MAX_SLOTS = 64;

	localparam int CMD_W    = 2;
	localparam int IDX_W    = 6;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 7;
	localparam int STATE_W  = 8;
	// Address field of the memory request; wide enough for the largest ring.
	localparam int ADDR_W   = 8;

	localparam logic [STATE_W-1:0] SLOT_EMPTY    = 8'h00;
	localparam logic [STATE_W-1:0] AGE_MAX       = 8'hFE;
	localparam logic [STATE_W-1:0] SLOT_RESERVED = 8'hFF;
	localparam logic [STATE_W-1:0] AGE_FIRST     = 8'h01;

	localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OVERWRITE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ALL_RSV   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_USED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_ARG   = 3'd4;

	typedef struct packed {
		logic               rd_en;
		logic [ADDR_W-1:0]  rd_addr;
		logic               wr_en;
		logic [ADDR_W-1:0]  wr_addr;
		logic [STATE_W-1:0] wr_data;
		logic               clear;
	} mem_req_t;

	// Age stamps run from 1 to 0xFE and then wrap back to 1.
	function automatic logic [STATE_W-1:0] next_age(input logic [STATE_W-1:0] a);
		return (a == AGE_MAX) ? AGE_FIRST : STATE_W'(a + 8'd1);
	endfunction

endpackage

/* rtl/core/reserved_circular_slot_allocator.sv */
// ----------------------------------------------------------------------------
// reserved_circular_slot_allocator
// Ring of slots with acquire, reserve-oldest and release commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and its single
// result appears on status and slot_index, marked by done for one cycle; the
// receiver cannot stall, so results must be captured when done is high.
// All slot states live in a one-port-read, one-port-write memory that is read
// one entry per cycle, and that memory port sets the time per command.
// With N the programmed slot_count: an acquire keeps busy high through a head
// scan of up to N reads, then, when every slot is used, a tail check and a
// tail scan of up to N reads; a reserve keeps it high through a tail check and
// a tail scan of up to N reads; a release through a single check read; a
// command rejected at once (unknown code, release index out of range, reserve
// with no used slots) raises no busy. The result is presented in the cycle in
// which busy falls; a command that is rejected at once answers in the cycle
// right after it is taken. Writing slot_count clears every slot in the same
// cycle and resets the pointers and the age counter.
// ----------------------------------------------------------------------------
module reserved_circular_slot_allocator #(
	parameter int MAX_SLOTS = rcsa_pkg::DEF_MAX_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rcsa_pkg::CMD_W-1:0]    command,
	input  logic [rcsa_pkg::IDX_W-1:0]    release_index,
	input  logic                          cfg_we,
	input  logic [rcsa_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                          done,
	output logic [rcsa_pkg::STATUS_W-1:0] status,
	output logic [rcsa_pkg::IDX_W-1:0]    slot_index
);
	import rcsa_pkg::*;

	mem_req_t           mem_req;
	logic [STATE_W-1:0] rdata;

	rcsa_ctrl #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.release_index(release_index),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.status       (status),
		.slot_index   (slot_index),
		.mem_req      (mem_req),
		.rdata        (rdata)
	);

	rcsa_slot_mem #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mem_req),
		.rdata (rdata)
	);

	// Failed commands always report slot zero.
	a_err_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK && status != ST_OVERWRITE) |-> (slot_index == '0))
		else $error("error result carries a nonzero slot index");

	// An accepted command either answers at once or holds busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cfg_we) |=> (busy || done))
		else $error("accepted command neither busy nor answered");

	// An overwrite is only found after a scan, never from an idle decision.
	a_ovw_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OVERWRITE) |-> $past(busy))
		else $error("overwrite result without a preceding scan");

endmodule

/* rtl/core/rcsa_slot_mem.sv */
// ----------------------------------------------------------------------------
// rcsa_slot_mem
// Slot state memory: one write and one read port, read data registered.
// A valid bit per entry makes a cleared or never written slot read as empty.
// ----------------------------------------------------------------------------
module rcsa_slot_mem #(
	parameter int MAX_SLOTS = rcsa_pkg::DEF_MAX_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcsa_pkg::mem_req_t            req,
	output logic [rcsa_pkg::STATE_W-1:0]  rdata
);
	import rcsa_pkg::*;

	localparam int PW = $clog2(MAX_SLOTS);

	logic [STATE_W-1:0]   mem [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] valid_q;
	logic [STATE_W-1:0]   raw_s1;
	logic                 vld_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[PW-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			raw_s1 <= mem[req.rd_addr[PW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr[PW-1:0]] <= 1'b1;
			end
			if (req.rd_en) begin
				vld_s1 <= valid_q[req.rd_addr[PW-1:0]];
			end
		end
	end

	assign rdata = vld_s1 ? raw_s1 : SLOT_EMPTY;

endmodule

/* rtl/core/rcsa_ctrl.sv */
// ----------------------------------------------------------------------------
// rcsa_ctrl
// Command sequencer: holds the ring pointers, use count and age counter,
// scans the slot memory one entry per cycle and writes back the result.
// ----------------------------------------------------------------------------
module rcsa_ctrl #(
	parameter int MAX_SLOTS = rcsa_pkg::DEF_MAX_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rcsa_pkg::CMD_W-1:0]    command,
	input  logic [rcsa_pkg::IDX_W-1:0]    release_index,
	input  logic                          cfg_we,
	input  logic [rcsa_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                          done,
	output logic [rcsa_pkg::STATUS_W-1:0] status,
	output logic [rcsa_pkg::IDX_W-1:0]    slot_index,
	output rcsa_pkg::mem_req_t            mem_req,
	input  logic [rcsa_pkg::STATE_W-1:0]  rdata
);
	import rcsa_pkg::*;

	localparam int PW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_HSCAN   = 3'd1;
	localparam logic [2:0] S_OVW_CHK = 3'd2;
	localparam logic [2:0] S_RSV_CHK = 3'd3;
	localparam logic [2:0] S_TSCAN   = 3'd4;
	localparam logic [2:0] S_REL_CHK = 3'd5;

	logic [2:0]          state_q;
	logic [PW-1:0]       head_q, tail_q, p_q, t_q, idx_q;
	logic [CW-1:0]       used_q, count_q, n_q;
	logic [STATE_W-1:0]  age_q, want_q;
	logic                ovw_q, done_q;
	logic [STATUS_W-1:0] status_q;

	logic                accept, n_last, rel_ok;
	logic [PW-1:0]       p_next, tail_next, rd_addr;
	logic [CW-1:0]       clamp;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p,
			input logic [CW-1:0] cnt);
		logic [CW-1:0] inc;
		inc = CW'(p) + CW'(1);
		return (inc >= cnt) ? '0 : PW'(inc);
	endfunction

	assign accept    = start && (state_q == S_IDLE);
	assign p_next    = ring_next(p_q, count_q);
	assign tail_next = ring_next(tail_q, count_q);
	assign n_last    = (n_q + CW'(1)) == count_q;
	assign rel_ok    = int'(release_index) < int'(count_q);

	always_comb begin
		if (int'(cfg_wdata) < 2) begin
			clamp = CW'(2);
		end else if (int'(cfg_wdata) > MAX_SLOTS) begin
			clamp = CW'(MAX_SLOTS);
		end else begin
			clamp = CW'(cfg_wdata);
		end
	end

	// Read address for the entry whose data is needed in the next cycle.
	always_comb begin
		rd_addr = p_next;
		unique case (state_q)
			S_IDLE: begin
				if (command == CMD_RELEASE) begin
					rd_addr = PW'(release_index);
				end else if (command == CMD_ACQUIRE) begin
					rd_addr = head_q;
				end else begin
					rd_addr = tail_q;
				end
			end
			S_HSCAN:   rd_addr = n_last ? tail_q : p_next;
			S_OVW_CHK: rd_addr = tail_next;
			S_RSV_CHK: rd_addr = tail_next;
			default:   rd_addr = p_next;
		endcase
	end

	always_comb begin
		mem_req         = '0;
		mem_req.rd_en   = accept || (state_q != S_IDLE);
		mem_req.rd_addr = ADDR_W'(rd_addr);
		mem_req.clear   = cfg_we;
		mem_req.wr_addr = ADDR_W'(p_q);
		mem_req.wr_data = SLOT_EMPTY;
		unique case (state_q)
			S_HSCAN: begin
				mem_req.wr_en   = (rdata == SLOT_EMPTY);
				mem_req.wr_data = age_q;
			end
			S_TSCAN: begin
				mem_req.wr_en   = (rdata == want_q) || n_last;
				mem_req.wr_addr = ADDR_W'(t_q);
				mem_req.wr_data = ovw_q ? age_q : SLOT_RESERVED;
			end
			S_REL_CHK: begin
				mem_req.wr_en = (rdata == SLOT_RESERVED);
			end
			default: mem_req.wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			used_q   <= '0;
			age_q    <= AGE_FIRST;
			count_q  <= CW'(MAX_SLOTS < 64 ? MAX_SLOTS : 64);
			done_q   <= 1'b0;
			status_q <= ST_OK;
			idx_q    <= '0;
			p_q      <= '0;
			t_q      <= '0;
			n_q      <= '0;
			want_q   <= SLOT_EMPTY;
			ovw_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				count_q <= clamp;
				head_q  <= '0;
				tail_q  <= '0;
				used_q  <= '0;
				age_q   <= AGE_FIRST;
				state_q <= S_IDLE;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept) begin
							p_q <= head_q;
							n_q <= '0;
							case (command)
								CMD_ACQUIRE: state_q <= S_HSCAN;
								CMD_RESERVE: begin
									if (used_q == '0) begin
										done_q   <= 1'b1;
										status_q <= ST_NO_USED;
										idx_q    <= '0;
									end else begin
										state_q <= S_RSV_CHK;
									end
								end
								CMD_RELEASE: begin
									if (rel_ok) begin
										p_q     <= PW'(release_index);
										state_q <= S_REL_CHK;
									end else begin
										done_q   <= 1'b1;
										status_q <= ST_BAD_ARG;
										idx_q    <= '0;
									end
								end
								default: begin
									done_q   <= 1'b1;
									status_q <= ST_BAD_ARG;
									idx_q    <= '0;
								end
							endcase
						end
					end
					S_HSCAN: begin
						if (rdata == SLOT_EMPTY) begin
							head_q   <= p_next;
							used_q   <= used_q + CW'(1);
							age_q    <= next_age(age_q);
							done_q   <= 1'b1;
							status_q <= ST_OK;
							idx_q    <= p_q;
							state_q  <= S_IDLE;
						end else if (n_last) begin
							// Whole ring is full; the scan has come round through every slot from the head.
							state_q <= S_OVW_CHK;
						end else begin
							p_q <= p_next;
							n_q <= n_q + CW'(1);
						end
					end
					S_OVW_CHK, S_RSV_CHK: begin
						if (rdata == SLOT_RESERVED) begin
							done_q   <= 1'b1;
							status_q <= ST_ALL_RSV;
							idx_q    <= '0;
							state_q  <= S_IDLE;
						end else if (rdata == SLOT_EMPTY && state_q == S_RSV_CHK) begin
							done_q   <= 1'b1;
							status_q <= ST_NO_USED;
							idx_q    <= '0;
							state_q  <= S_IDLE;
						end else begin
							want_q  <= next_age(rdata);
							ovw_q   <= (state_q == S_OVW_CHK);
							t_q     <= tail_q;
							p_q     <= tail_next;
							n_q     <= '0;
							state_q <= S_TSCAN;
						end
					end
					S_TSCAN: begin
						if ((rdata == want_q) || n_last) begin
							// The tail only moves when a slot with the next age exists.
							if (rdata == want_q) begin
								tail_q <= p_q;
							end
							if (ovw_q) begin
								head_q   <= t_q;
								age_q    <= next_age(age_q);
								status_q <= ST_OVERWRITE;
							end else begin
								used_q   <= used_q - CW'(1);
								status_q <= ST_OK;
							end
							done_q  <= 1'b1;
							idx_q   <= t_q;
							state_q <= S_IDLE;
						end else begin
							p_q <= p_next;
							n_q <= n_q + CW'(1);
						end
					end
					S_REL_CHK: begin
						done_q <= 1'b1;
						if (rdata == SLOT_RESERVED) begin
							status_q <= ST_OK;
							idx_q    <= p_q;
						end else begin
							status_q <= ST_BAD_ARG;
							idx_q    <= '0;
						end
						state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign slot_index = IDX_W'(idx_q);

endmodule

/* bench/reserved_circular_slot_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reserved_circular_slot_allocator_tb
// Self-checking bench for the slot ring: a directed table of acquire, reserve,
// release and unknown commands with slot_count writes, then random phases at
// several ring sizes. Every transfer is checked against a behavioral copy of the
// ring kept in the bench, or against the literal result that a directed row gives.
// ----------------------------------------------------------------------------
module reserved_circular_slot_allocator_tb;
	import rcsa_pkg::*;

	localparam int SLOTS = DEF_MAX_SLOTS;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] st;
		logic [IDX_W-1:0]    ix;
	} slot_reply_t;

	typedef struct packed {
		logic                is_cfg;
		logic [CFG_W-1:0]    cfg_val;
		logic [CMD_W-1:0]    cmd;
		logic [IDX_W-1:0]    ridx;
		logic                has_lit;
		logic [STATUS_W-1:0] lit_st;
		logic [IDX_W-1:0]    lit_ix;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 26;
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{1'b0, 7'd0,   CMD_RESERVE, 6'd0,  1'b1, ST_NO_USED, 6'd0},
		'{1'b0, 7'd0,   CMD_RELEASE, 6'd5,  1'b1, ST_BAD_ARG, 6'd0},
		'{1'b0, 7'd0,   CMD_UNKNOWN, 6'd63, 1'b1, ST_BAD_ARG, 6'd0},
		'{1'b0, 7'd0,   CMD_ACQUIRE, 6'd0,  1'b1, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_ACQUIRE, 6'd0,  1'b1, ST_OK,      6'd1},
		'{1'b0, 7'd0,   CMD_RESERVE, 6'd0,  1'b1, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_RELEASE, 6'd0,  1'b1, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_RELEASE, 6'd63, 1'b1, ST_BAD_ARG, 6'd0},
		'{1'b1, 7'd0,   CMD_ACQUIRE, 6'd0,  1'b0, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_ACQUIRE, 6'd0,  1'b1, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_ACQUIRE, 6'd0,  1'b1, ST_OK,      6'd1},
		// The two-slot ring is now full: overwrite, then reserve both slots.
		'{1'b0, 7'd0,   CMD_ACQUIRE, 6'd0,  1'b0, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_RESERVE, 6'd0,  1'b0, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_RESERVE, 6'd0,  1'b0, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_ACQUIRE, 6'd0,  1'b0, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_RESERVE, 6'd0,  1'b0, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_RELEASE, 6'd2,  1'b0, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_RELEASE, 6'd1,  1'b0, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_ACQUIRE, 6'd0,  1'b0, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_RESERVE, 6'd0,  1'b0, ST_OK,      6'd0},
		'{1'b1, 7'd1,   CMD_ACQUIRE, 6'd0,  1'b0, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_ACQUIRE, 6'd0,  1'b0, ST_OK,      6'd0},
		'{1'b1, 7'd127, CMD_ACQUIRE, 6'd0,  1'b0, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_ACQUIRE, 6'd0,  1'b0, ST_OK,      6'd0},
		'{1'b0, 7'd0,   CMD_RELEASE, 6'd63, 1'b0, ST_OK,      6'd0},
		'{1'b1, 7'd64,  CMD_ACQUIRE, 6'd0,  1'b0, ST_OK,      6'd0}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [CMD_W-1:0]    command = '0;
	logic [IDX_W-1:0]    release_index = '0;
	logic                cfg_we = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    slot_index;

	// Bench copy of the ring.
	logic [STATE_W-1:0] ring_state [SLOTS];
	int                 ring_len;
	int                 head_at;
	int                 tail_at;
	int                 used_slots;
	logic [STATE_W-1:0] age_now;

	slot_reply_t replies_due [$];
	int          error_count = 0;
	int          cycle_count = 0;
	int          commands_sent = 0;
	int          cfg_writes = 0;
	int          sender_idle_pct = 0;
	int          status_tally [8];

	reserved_circular_slot_allocator #(
		.MAX_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.release_index(release_index),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.status(status),
		.slot_index(slot_index)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [STATE_W-1:0] age_after(input logic [STATE_W-1:0] a);
		return (a == AGE_MAX) ? AGE_FIRST : STATE_W'(a + 8'd1);
	endfunction

	function automatic int ring_step(input int p);
		return (p + 1 >= ring_len) ? 0 : p + 1;
	endfunction

	function automatic void wipe_ring(input int len);
		int i;
		for (i = 0; i < SLOTS; i++) ring_state[i] = SLOT_EMPTY;
		ring_len = len;
		head_at = 0;
		tail_at = 0;
		used_slots = 0;
		age_now = AGE_FIRST;
	endfunction

	// The tail follows the stamp one age newer than its own; if no slot holds
	// that stamp, the tail stays put.
	function automatic void advance_tail();
		logic [STATE_W-1:0] wanted;
		int p;
		int i;
		wanted = age_after(ring_state[tail_at]);
		p = tail_at;
		for (i = 0; i < ring_len; i++) begin
			p = ring_step(p);
			if (ring_state[p] != SLOT_RESERVED && ring_state[p] != SLOT_EMPTY &&
				ring_state[p] == wanted) begin
				tail_at = p;
				return;
			end
		end
	endfunction

	function automatic slot_reply_t compute_slot_response(input logic [CMD_W-1:0] cmd,
			input logic [IDX_W-1:0] ridx);
		slot_reply_t r;
		bit found;
		int i;
		int t;
		r.st = ST_BAD_ARG;
		r.ix = '0;
		found = 1'b0;
		case (cmd)
			CMD_ACQUIRE: begin
				for (i = 0; i < ring_len && !found; i++) begin
					if (ring_state[head_at] == SLOT_EMPTY) begin
						r.ix = IDX_W'(head_at);
						ring_state[head_at] = age_now;
						used_slots = (used_slots + 1) & 127;
						head_at = ring_step(head_at);
						age_now = age_after(age_now);
						r.st = ST_OK;
						found = 1'b1;
					end else begin
						head_at = ring_step(head_at);
					end
				end
				if (!found) begin
					t = tail_at;
					if (ring_state[t] != SLOT_RESERVED) begin
						r.ix = IDX_W'(t);
						advance_tail();
						head_at = t;
						ring_state[t] = age_now;
						age_now = age_after(age_now);
						r.st = ST_OVERWRITE;
					end else begin
						r.st = ST_ALL_RSV;
					end
				end
			end
			CMD_RESERVE: begin
				t = tail_at;
				if (used_slots == 0 || ring_state[t] == SLOT_EMPTY) begin
					r.st = ST_NO_USED;
				end else if (ring_state[t] == SLOT_RESERVED) begin
					r.st = ST_ALL_RSV;
				end else begin
					advance_tail();
					r.ix = IDX_W'(t);
					ring_state[t] = SLOT_RESERVED;
					used_slots = (used_slots - 1) & 127;
					r.st = ST_OK;
				end
			end
			CMD_RELEASE: begin
				if (int'(ridx) < ring_len && ring_state[ridx] == SLOT_RESERVED) begin
					ring_state[ridx] = SLOT_EMPTY;
					r.ix = ridx;
					r.st = ST_OK;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		error_count++;
		$display("[%0t] MISMATCH %s", $time, what);
	endtask

	// Holds start for one command until it is taken, then books its result.
	task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] ridx,
			input bit has_lit, input slot_reply_t lit);
		slot_reply_t r;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		release_index <= ridx;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = compute_slot_response(cmd, ridx);
		if (has_lit) r = lit;
		replies_due.push_back(r);
		status_tally[r.st]++;
		commands_sent++;
	endtask

	task automatic program_slot_count(input logic [CFG_W-1:0] v);
		int len;
		start <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		len = int'(v);
		if (len < 2) len = 2;
		if (len > SLOTS) len = SLOTS;
		wipe_ring(len);
		cfg_writes++;
	endtask

	// Releases mostly aim at slots that are currently reserved.
	function automatic logic [IDX_W-1:0] pick_release_target();
		int held [$];
		int i;
		for (i = 0; i < ring_len; i++)
			if (ring_state[i] == SLOT_RESERVED) held.push_back(i);
		if (held.size() != 0 && $urandom_range(0, 99) < 70)
			return IDX_W'(held[$urandom_range(0, held.size() - 1)]);
		return IDX_W'($urandom_range(0, 63));
	endfunction

	task automatic run_random_phase(input int count, input int acquire_pct);
		int k;
		int roll;
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] ridx;
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			ridx = IDX_W'($urandom_range(0, 63));
			if (roll < acquire_pct) begin
				cmd = CMD_ACQUIRE;
			end else if (roll < acquire_pct + (95 - acquire_pct) / 2) begin
				cmd = CMD_RESERVE;
			end else if (roll < 95) begin
				cmd = CMD_RELEASE;
				ridx = pick_release_target();
			end else begin
				cmd = CMD_UNKNOWN;
			end
			issue_command(cmd, ridx, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		slot_reply_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected transfer status=%0d slot_index=%0d",
					status, slot_index));
			end else begin
				want = replies_due.pop_front();
				if (status !== want.st)
					flag_mismatch($sformatf("status got %0d want %0d", status, want.st));
				if (slot_index !== want.ix)
					flag_mismatch($sformatf("slot_index got %0d want %0d",
						slot_index, want.ix));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, replies_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int r;
		for (r = 0; r < 8; r++) status_tally[r] = 0;
		wipe_ring(SLOTS);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < DIRECTED_ROWS; r++) begin
			if (DIRECTED[r].is_cfg)
				program_slot_count(DIRECTED[r].cfg_val);
			else
				issue_command(DIRECTED[r].cmd, DIRECTED[r].ridx, DIRECTED[r].has_lit,
					'{DIRECTED[r].lit_st, DIRECTED[r].lit_ix});
		end

		sender_idle_pct = 21;
		program_slot_count(7'd3);
		run_random_phase(250, 45);
		// A long acquire-heavy run on the full ring lets the age stamp wrap.
		program_slot_count(7'd64);
		run_random_phase(400, 65);

		sender_idle_pct = 86;
		program_slot_count(7'd5);
		run_random_phase(250, 45);
		program_slot_count(CFG_W'($urandom_range(2, 12)));
		run_random_phase(250, 50);

		sender_idle_pct = 0;
		program_slot_count(7'd127);
		run_random_phase(200, 45);
		program_slot_count(7'd1);
		run_random_phase(200, 40);
		program_slot_count(CFG_W'($urandom_range(0, 127)));
		run_random_phase(275, 45);

		start <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (2 * SLOTS + 8) @(posedge clk);

		$display("Sent %0d commands across %0d slot_count writes in %0d cycles.",
			commands_sent, cfg_writes, cycle_count);
		$display("Results: ok %0d, overwrite %0d, all reserved %0d, none used %0d, bad %0d.",
			status_tally[ST_OK], status_tally[ST_OVERWRITE], status_tally[ST_ALL_RSV],
			status_tally[ST_NO_USED], status_tally[ST_BAD_ARG]);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
